[rtl/core/mba_pkg.sv]
package mba_pkg;

  localparam int NUM_SHARES = 2;
  localparam int SLICE_BITS = 32;
  localparam int SHARE_W    = 32;
  localparam int NUM_PAIRS  = NUM_SHARES * (NUM_SHARES - 1) / 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [SHARE_W-1:0] lane_t;
  typedef lane_t [NUM_SHARES-1:0] shares_t;
  typedef lane_t [NUM_PAIRS-1:0] pairs_t;

  localparam lane_t LANE_MASK = lane_t'((64'd1 << SLICE_BITS) - 64'd1);

  // register index within the config map (byte address >> 2)
  typedef enum logic [0:0] {
    REG_CARRY_OUT_ENABLE = 1'b0
  } cfg_reg_t;

  typedef struct packed {
    shares_t sum;
    shares_t carry;
  } slice_res_t;

endpackage

[rtl/core/mba_sec_and.sv]
module mba_sec_and (
  input  mba_pkg::shares_t a,
  input  mba_pkg::shares_t b,
  input  mba_pkg::pairs_t  rnd,
  output mba_pkg::shares_t z
);
  import mba_pkg::*;

  shares_t t;

  always_comb begin
    int p;
    lane_t r;
    p = 0;
    r = '0;
    for (int i = 0; i < NUM_SHARES; i++) begin
      t[i] = a[i] & b[i];
    end
    // one cross term pair per share pair, same random word on both sides
    for (int i = 0; i < NUM_SHARES - 1; i++) begin
      for (int j = i + 1; j < NUM_SHARES; j++) begin
        r = rnd[p] & LANE_MASK;
        p++;
        t[i] = t[i] ^ (((b[j] ^ r) & a[i]) ^ (r & ~a[i]));
        t[j] = t[j] ^ (((b[i] ^ r) & a[j]) ^ (r & ~a[j]));
      end
    end
    for (int i = 0; i < NUM_SHARES; i++) begin
      z[i] = t[i] & LANE_MASK;
    end
  end

endmodule

[rtl/core/mba_slice.sv]
module mba_slice (
  input  mba_pkg::shares_t    x,
  input  mba_pkg::shares_t    y,
  input  mba_pkg::shares_t    carry,
  input  logic                first,
  input  mba_pkg::pairs_t     rnd,
  output mba_pkg::slice_res_t res
);
  import mba_pkg::*;

  shares_t xm;
  shares_t ym;
  shares_t xpy;
  shares_t and_b;
  shares_t and_z;

  always_comb begin
    for (int k = 0; k < NUM_SHARES; k++) begin
      xm[k]  = x[k] & LANE_MASK;
      ym[k]  = y[k] & LANE_MASK;
      xpy[k] = xm[k] ^ ym[k];
      // first slice: and(x, y); later: and(x^y, x^c)
      and_b[k] = first ? ym[k] : (xm[k] ^ carry[k]);
    end
  end

  mba_sec_and u_and (
    .a   (first ? xm : xpy),
    .b   (and_b),
    .rnd (rnd),
    .z   (and_z)
  );

  always_comb begin
    for (int k = 0; k < NUM_SHARES; k++) begin
      res.sum[k]   = first ? xpy[k] : (xpy[k] ^ carry[k]);
      res.carry[k] = first ? and_z[k] : ((and_z[k] ^ xm[k]) & LANE_MASK);
    end
  end

endmodule

[rtl/core/mba_cfg.sv]
module mba_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mba_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mba_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mba_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic                           carry_out_enable
);
  import mba_pkg::*;

  logic     co_en_r;
  logic     co_en_nxt;
  cfg_reg_t reg_idx;

  assign reg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready  = 1'b1;

  always_comb begin
    co_en_nxt = co_en_r;
    if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_CARRY_OUT_ENABLE: co_en_nxt = pwdata[0];
        default:              co_en_nxt = co_en_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CARRY_OUT_ENABLE: prdata = {{(CFG_DATA_W-1){1'b0}}, co_en_r};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      co_en_r <= 1'b0;
    end else begin
      co_en_r <= co_en_nxt;
    end
  end

  assign carry_out_enable = co_en_r;

endmodule

[rtl/core/masked_bitsliced_adder_unit.sv]
// channel   | dir | handshake           | payload
// ----------+-----+---------------------+------------------------------------------
// in_       | in  | in_valid / in_stall | operand shares, random word, last_slice
// out_      | out | out_valid/out_stall | sum shares, is_carry_out, last_result
// config    | in  | apb psel/penable    | carry_out_enable at byte address 0
//
// one slice beat per cycle unless stalled; each passes input then result register
// the carry register closes through one masked and, with no register between
// a last slice with carry-out enabled yields two result beats, so the input
// register holds the next slice while the carry-out beat goes out
// rst_n (synchronous) clears valids, carry chain and the config register
// out_stall holds the result register; input keeps flowing while stages are free
module masked_bitsliced_adder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [63:0]                    in_first_operand_shares,
  input  logic [63:0]                    in_second_operand_shares,
  input  logic [31:0]                    in_random_words,
  input  logic                           in_last_slice,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [63:0]                    out_sum_shares,
  output logic                           out_is_carry_out,
  output logic                           out_last_result,
  // config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mba_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mba_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mba_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import mba_pkg::*;

  logic co_en;

  // input register stage
  logic    s1_vld_r,  s1_vld_nxt;
  shares_t s1_x_r;
  shares_t s1_y_r;
  pairs_t  s1_rnd_r;
  logic    s1_last_r;

  // carry chain state
  shares_t carry_r,   carry_nxt;
  logic    first_r,   first_nxt;

  // result register and pending carry-out beat
  logic    out_vld_r, out_vld_nxt;
  shares_t out_sum_r, out_sum_nxt;
  logic    out_co_r,  out_co_nxt;
  logic    out_lst_r, out_lst_nxt;
  logic    co_vld_r,  co_vld_nxt;
  shares_t co_sum_r,  co_sum_nxt;

  slice_res_t res;
  logic       in_take;
  logic       out_free;
  logic       s1_adv;
  logic       emit_co;

  mba_cfg u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .carry_out_enable (co_en)
  );

  mba_slice u_slice (
    .x     (s1_x_r),
    .y     (s1_y_r),
    .carry (carry_r),
    .first (first_r),
    .rnd   (s1_rnd_r),
    .res   (res)
  );

  // result slot frees when empty or being taken this edge
  assign out_free = !out_vld_r || !out_stall;
  // a waiting carry-out beat goes first, the slice in stage 1 waits behind it
  assign s1_adv   = s1_vld_r && out_free && !co_vld_r;
  assign emit_co  = s1_last_r && co_en;
  assign in_stall = s1_vld_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    carry_nxt   = carry_r;
    first_nxt   = first_r;
    out_vld_nxt = out_vld_r;
    out_sum_nxt = out_sum_r;
    out_co_nxt  = out_co_r;
    out_lst_nxt = out_lst_r;
    co_vld_nxt  = co_vld_r;
    co_sum_nxt  = co_sum_r;

    if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
    if (in_take) begin
      s1_vld_nxt = 1'b1;
    end

    if (out_free) begin
      out_vld_nxt = 1'b0;
    end

    if (co_vld_r && out_free) begin
      // move the carry-out beat into the result register
      out_vld_nxt = 1'b1;
      out_sum_nxt = co_sum_r;
      out_co_nxt  = 1'b1;
      out_lst_nxt = 1'b1;
      co_vld_nxt  = 1'b0;
    end else if (s1_adv) begin
      out_vld_nxt = 1'b1;
      out_sum_nxt = res.sum;
      out_co_nxt  = 1'b0;
      out_lst_nxt = s1_last_r && !co_en;
      if (emit_co) begin
        co_vld_nxt = 1'b1;
        co_sum_nxt = res.carry;
      end
      // end of an addition restarts the chain
      if (s1_last_r) begin
        carry_nxt = '0;
        first_nxt = 1'b1;
      end else begin
        carry_nxt = res.carry;
        first_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      carry_r   <= '0;
      first_r   <= 1'b1;
      out_vld_r <= 1'b0;
      co_vld_r  <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      carry_r   <= carry_nxt;
      first_r   <= first_nxt;
      out_vld_r <= out_vld_nxt;
      co_vld_r  <= co_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_x_r    <= shares_t'(in_first_operand_shares);
      s1_y_r    <= shares_t'(in_second_operand_shares);
      s1_rnd_r  <= pairs_t'(in_random_words);
      s1_last_r <= in_last_slice;
    end
    out_sum_r <= out_sum_nxt;
    out_co_r  <= out_co_nxt;
    out_lst_r <= out_lst_nxt;
    co_sum_r  <= co_sum_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_sum_shares   = 64'(out_sum_r);
  assign out_is_carry_out = out_co_r;
  assign out_last_result  = out_lst_r;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import mba_pkg::*;

  // beat that the adder should return, oldest first
  typedef struct {
    logic [63:0] sum;
    logic        is_cout;
    logic        last;
  } sum_beat_t;

  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [63:0] PAT_A    = 64'haaaa_aaaa_aaaa_aaaa;
  localparam logic [63:0] PAT_5    = 64'h5555_5555_5555_5555;

  logic clk = 1'b0;
  logic rst_n;

  // input channel
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_first_operand_shares;
  logic [63:0] in_second_operand_shares;
  logic [31:0] in_random_words;
  logic        in_last_slice;

  // result channel
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_sum_shares;
  logic        out_is_carry_out;
  logic        out_last_result;

  // register port
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor state: carry shares, start-of-addition flag and register copy
  shares_t carry_lanes;
  logic    first_slice;
  logic    cout_en;

  sum_beat_t expected_sums[$];
  int        mismatches;

  // idling controls: quiet phases give back-to-back stretches
  bit quiet_tx;
  bit quiet_rx;
  int stall_left;

  masked_bitsliced_adder_unit DUT (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_first_operand_shares  (in_first_operand_shares),
    .in_second_operand_shares (in_second_operand_shares),
    .in_random_words          (in_random_words),
    .in_last_slice            (in_last_slice),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_sum_shares           (out_sum_shares),
    .out_is_carry_out         (out_is_carry_out),
    .out_last_result          (out_last_result),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // pini masked and, one random lane word per share pair (i < j)
  function automatic shares_t pini_and(shares_t a, shares_t b, pairs_t r);
    shares_t t;
    lane_t   rw;
    int      p;
    p = 0;
    for (int i = 0; i < NUM_SHARES; i++) t[i] = a[i] & b[i];
    for (int i = 0; i + 1 < NUM_SHARES; i++) begin
      for (int j = i + 1; j < NUM_SHARES; j++) begin
        rw = r[p] & LANE_MASK;
        t[i] ^= ((b[j] ^ rw) & a[i]) ^ (rw & ~a[i]);
        t[j] ^= ((b[i] ^ rw) & a[j]) ^ (rw & ~a[j]);
        p++;
      end
    end
    for (int i = 0; i < NUM_SHARES; i++) t[i] &= LANE_MASK;
    return t;
  endfunction

  // one accepted slice: queue the sum beat (and carry-out beat) it yields
  task automatic predict_slice(input logic [63:0] a, input logic [63:0] b,
                               input logic [31:0] r, input logic last);
    shares_t   x, y, xpy, xpc, sum, nc;
    sum_beat_t beat;
    x = shares_t'(a);
    y = shares_t'(b);
    for (int k = 0; k < NUM_SHARES; k++) begin
      x[k] &= LANE_MASK;
      y[k] &= LANE_MASK;
    end
    if (first_slice) begin
      // lowest slice: plain xor sum, carry is x and y
      sum = x ^ y;
      nc  = pini_and(x, y, pairs_t'(r));
    end else begin
      // carry = and(x^y, x^c) ^ x, i.e. majority of x, y, c
      xpy = x ^ y;
      xpc = x ^ carry_lanes;
      sum = xpy ^ carry_lanes;
      nc  = pini_and(xpy, xpc, pairs_t'(r));
      for (int k = 0; k < NUM_SHARES; k++) nc[k] = (nc[k] ^ x[k]) & LANE_MASK;
    end
    beat.sum     = 64'(sum);
    beat.is_cout = 1'b0;
    beat.last    = last && !cout_en;
    expected_sums.push_back(beat);
    if (last && cout_en) begin
      beat.sum     = 64'(nc);
      beat.is_cout = 1'b1;
      beat.last    = 1'b1;
      expected_sums.push_back(beat);
    end
    // a last slice closes the addition, the next one starts fresh
    if (last) begin
      carry_lanes = '0;
      first_slice = 1'b1;
    end else begin
      carry_lanes = nc;
      first_slice = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // one slice beat; valid stays high after acceptance so that
  // back-to-back beats never lower and raise it in the same step
  task automatic send_slice(input logic [63:0] a, input logic [63:0] b,
                            input logic [31:0] r, input logic last);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid                 <= 1'b1;
    in_first_operand_shares  <= a;
    in_second_operand_shares <= b;
    in_random_words          <= r;
    in_last_slice            <= last;
    do @(posedge clk); while (in_stall);
    predict_slice(a, b, r, last);
  endtask

  // drop valid and let every expected beat drain before touching registers
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb read with compare against the expected register value
  task automatic check_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] want);
    logic [CFG_DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(idx) << 2;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) report_mismatch("register readback", 64'(got), 64'(want));
  endtask

  // apb write (setup then access), followed by a readback
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << 2;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_CARRY_OUT_ENABLE) cout_en = val[0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_reg(idx, val & 32'h1);
  endtask

  // mostly random operand shares, now and then solid patterns for long carries
  function automatic logic [63:0] operand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return PAT_A;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall generator and checker
  // ---------------------------------------------------------------------------

  // stall count is drawn after every taken result beat
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    sum_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      stall_left <= quiet_rx ? 0 : $urandom_range(0, 11);
      if (expected_sums.size() == 0) begin
        report_mismatch("unexpected result beat", out_sum_shares, '0);
      end else begin
        want = expected_sums.pop_front();
        if (out_sum_shares !== want.sum)
          report_mismatch("sum_shares", out_sum_shares, want.sum);
        if (out_is_carry_out !== want.is_cout)
          report_mismatch("is_carry_out", 64'(out_is_carry_out), 64'(want.is_cout));
        if (out_last_result !== want.last)
          report_mismatch("last_result", 64'(out_last_result), 64'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // register reads back zero and carry-out stays off after reset
  task automatic test_reset_default();
    check_reg(REG_CARRY_OUT_ENABLE, '0);
    send_slice({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 1'b0);
    send_slice({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 1'b1);
  endtask

  // solid and alternating operands, carry through every lane,
  // random word on an unused last carry must not matter
  task automatic test_operand_extremes();
    write_reg(REG_CARRY_OUT_ENABLE, 32'h0);
    send_slice('0, '0, 32'h0, 1'b1);
    send_slice(ALL_ONES, ALL_ONES, 32'hffff_ffff, 1'b1);
    send_slice(ALL_ONES, '0, 32'h0, 1'b0);
    send_slice(PAT_A, PAT_5, 32'hffff_ffff, 1'b0);
    send_slice(ALL_ONES, ALL_ONES, 32'h1234_5678, 1'b1);
    // same two-slice addition twice, only the last random word differs
    send_slice(PAT_5, PAT_A, 32'h0, 1'b0);
    send_slice(PAT_5, PAT_A, 32'hffff_ffff, 1'b1);
    send_slice(PAT_5, PAT_A, 32'h0, 1'b0);
    send_slice(PAT_5, PAT_A, 32'h0, 1'b1);
  endtask

  // carry-out beat for one-slice operands and for a longer chain
  task automatic test_one_slice_carry_out();
    write_reg(REG_CARRY_OUT_ENABLE, 32'h1);
    send_slice('0, '0, 32'h0, 1'b1);
    send_slice(ALL_ONES, ALL_ONES, 32'hffff_ffff, 1'b1);
    send_slice(PAT_A, PAT_5, $urandom, 1'b1);
    send_slice(ALL_ONES, '0, 32'h0, 1'b1);
    send_slice(ALL_ONES, ALL_ONES, $urandom, 1'b0);
    send_slice(PAT_A, PAT_A, $urandom, 1'b0);
    send_slice(ALL_ONES, '0, $urandom, 1'b1);
  endtask

  // random additions in phases with both register settings and idling modes
  task automatic test_random_additions();
    int len;
    int sent;
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_CARRY_OUT_ENABLE, (phase < 2) ? 32'(phase) : 32'($urandom_range(0, 1)));
      quiet_tx = (phase % 4 == 2) || (phase == 7);
      quiet_rx = (phase % 4 == 3) || (phase == 7);
      sent = 0;
      while (sent < 190) begin
        // mostly short operands, a few long carry chains
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int s = 0; s < len; s++)
          send_slice(operand_word(), operand_word(), $urandom, s == len - 1);
        sent += len;
      end
    end
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n                    = 1'b0;
    in_valid                 = 1'b0;
    in_first_operand_shares  = '0;
    in_second_operand_shares = '0;
    in_random_words          = '0;
    in_last_slice            = 1'b0;
    out_stall                = 1'b0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    carry_lanes              = '0;
    first_slice              = 1'b1;
    cout_en                  = 1'b0;
    mismatches               = 0;
    quiet_tx                 = 1'b0;
    quiet_rx                 = 1'b0;
    stall_left               = 0;

    // synchronous reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_default();
    test_operand_extremes();
    test_one_slice_carry_out();
    test_random_additions();

    // drain, then allow the two-stage pipe to settle
    wait_idle();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS masked_bitsliced_adder_unit");
    end else begin
      $display("FAIL masked_bitsliced_adder_unit");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL masked_bitsliced_adder_unit");
    $finish;
  end

endmodule

[masked_bitsliced_adder_unit.f]
rtl/core/mba_pkg.sv
rtl/core/mba_sec_and.sv
rtl/core/mba_slice.sv
rtl/core/mba_cfg.sv
rtl/core/masked_bitsliced_adder_unit.sv
tb/sv/tb.sv
